// ----- rtl/pva_pkg.sv -----
// Shared constants, codes and types of the polyphonic voice allocator.
`default_nettype none

package pva_pkg;

    // Voice pool and field sizes
    localparam int VOICES      = 16;
    localparam int VOICE_W     = 4;
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int NOTES       = 128;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Input operation codes
    typedef enum logic [1:0] {
        OP_NOTE_ON    = 2'd0,
        OP_NOTE_OFF   = 2'd1,
        OP_ALL_OFF    = 2'd2,
        OP_VOICE_DONE = 2'd3
    } op_t;

    // Output command codes
    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_CANCEL  = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    // One position of the LRU row: the voice there and that voice's state
    typedef struct packed {
        logic [VOICE_W-1:0] id;
        logic               active;
        logic [NOTE_W-1:0]  key;
    } slot_t;

    // Controls broadcast to every cell of the row
    typedef struct packed {
        logic               shift;
        logic [VOICE_W-1:0] pos;
        logic               clear;
        logic [VOICE_W-1:0] fin;
        logic [NOTE_W-1:0]  note;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/polyphonic_voice_allocator.sv -----
// Top level: LRU voice allocator with stealing, built on a row of slot cells.
//
//  channel  | valid     | ready     | word
//  ---------+-----------+-----------+--------------------------------------------
//  input    | s_valid   | s_ready   | s_operation s_note s_velocity s_finished_voice
//  result   | m_valid   | m_ready   | m_command m_voice m_voice_note m_voice_velocity m_last
//  config   | cfg_valid | cfg_ready | cfg_data (sample_ready)
//
// A note on scans the LRU row one position per cycle, then sends a cancel word when a voice is
// reused or stolen, and the start word; all notes off scans one voice per cycle and reads the note
// map for each active voice before its release word, sent once the result register is free.
// Reset is synchronous; the note map valid bits clear at once, so there is no sweep.
// A stalled m_ready holds the result register and the block waits for it to drain;
// the next input word is taken as soon as the last result is in the register.
`default_nettype none

module polyphonic_voice_allocator
    import pva_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data,
    // input events
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_operation,
    input  wire logic [NOTE_W-1:0]  s_note,
    input  wire logic [VEL_W-1:0]   s_velocity,
    input  wire logic [VOICE_W-1:0] s_finished_voice,
    // voice commands
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_command,
    output logic [VOICE_W-1:0]      m_voice,
    output logic [NOTE_W-1:0]       m_voice_note,
    output logic [VEL_W-1:0]        m_voice_velocity,
    output logic                    m_last
);

    localparam logic [VOICE_W-1:0] LAST_SLOT = VOICE_W'(VOICES - 1);
    localparam int                 NOTE_AW   = $clog2(NOTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ON_SCAN,
        ST_ON_CANCEL,
        ST_ON_START,
        ST_OFF_WAIT,
        ST_ALL_SCAN,
        ST_ALL_WAIT
    } state_t;

    state_t              state_reg;
    logic                sample_ready_reg;
    logic [NOTE_W-1:0]   note_reg;
    logic [VEL_W-1:0]    vel_reg;
    logic [VOICE_W-1:0]  scan_cnt_reg;
    logic [VOICE_W-1:0]  pos_reg;
    logic [VOICE_W-1:0]  chosen_reg;
    logic                inact_found_reg;
    logic [VOICE_W-1:0]  inact_pos_reg;
    logic [VOICE_W-1:0]  inact_id_reg;
    logic [CNT_W-1:0]    rel_cnt_reg;
    logic [NOTES-1:0]    nv_valid_reg;
    logic                rd_hit_reg;

    logic                m_valid_reg;
    cmd_t                m_command_reg;
    logic [VOICE_W-1:0]  m_voice_reg;
    logic [NOTE_W-1:0]   m_voice_note_reg;
    logic [VEL_W-1:0]    m_voice_velocity_reg;
    logic                m_last_reg;

    slot_t               cells_q [VOICES];
    slot_t               new_slot;
    logic [VOICES-1:0]   match_vec;
    cell_ctrl_t          ctrl;

    logic                in_fire;
    logic                out_free;
    logic                out_load;
    logic                start_fire;
    slot_t               scan_slot;
    logic [VOICES-1:0]   act_vec;
    logic [VOICES-1:0]   act_above;
    logic                more_active;
    logic [NOTE_W-1:0]   scan_key;
    logic                rd_en;
    logic [NOTE_AW-1:0]  rd_addr;
    logic [VOICE_W-1:0]  rd_data;
    logic [VOICE_W-1:0]  mapped_voice;
    logic                rel_last;
    logic [VOICES-1:0]   id0_vec;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign start_fire = (state_reg == ST_ON_START) && out_free;

    // Load a new result word in any emitting state once the register is free
    assign out_load = out_free && ((state_reg == ST_ON_CANCEL) || (state_reg == ST_ON_START) ||
                                   (state_reg == ST_OFF_WAIT) || (state_reg == ST_ALL_WAIT));

    // Row of slot cells, oldest at position zero
    assign ctrl.shift = start_fire;
    assign ctrl.pos   = pos_reg;
    assign ctrl.clear = in_fire && (s_operation == OP_VOICE_DONE);
    assign ctrl.fin   = s_finished_voice;
    assign ctrl.note  = note_reg;

    assign new_slot.id     = chosen_reg;
    assign new_slot.active = 1'b1;
    assign new_slot.key    = note_reg;

    for (genvar k = 0; k < VOICES; k++) begin : g_cell
        slot_t nb;
        if (k == VOICES - 1) begin : g_tail
            assign nb = new_slot;
        end else begin : g_body
            assign nb = cells_q[k+1];
        end
        pva_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .slot_idx (VOICE_W'(k)),
            .ctrl     (ctrl),
            .nb_in    (nb),
            .q        (cells_q[k]),
            .match    (match_vec[k])
        );
        assign id0_vec[k] = (cells_q[k].id == '0);
    end

    // Slot under the scan counter, by position
    assign scan_slot = cells_q[scan_cnt_reg];

    // Active flags by voice index and the key of the voice under the scan counter
    always_comb begin
        act_vec  = '0;
        scan_key = '0;
        for (int v = 0; v < VOICES; v++) begin
            for (int k = 0; k < VOICES; k++) begin
                if (cells_q[k].active && (cells_q[k].id == VOICE_W'(v))) begin
                    act_vec[v] = 1'b1;
                end
            end
        end
        for (int k = 0; k < VOICES; k++) begin
            if (cells_q[k].active && (cells_q[k].id == scan_cnt_reg)) begin
                scan_key = scan_key | cells_q[k].key;
            end
        end
    end

    assign act_above   = act_vec >> scan_cnt_reg;
    assign more_active = |act_above[VOICES-1:1];
    assign rel_last    = !more_active || (rel_cnt_reg == CNT_W'(MAX_RESULTS - 1));

    // Note map: read for note off and all notes off, written by note on
    assign rd_en   = (in_fire && (s_operation == OP_NOTE_OFF) && sample_ready_reg) ||
                     ((state_reg == ST_ALL_SCAN) && act_vec[scan_cnt_reg]);
    assign rd_addr = (state_reg == ST_IDLE) ? s_note : scan_key;

    pva_ram #(
        .WIDTH (VOICE_W),
        .DEPTH (NOTES)
    ) u_note_map (
        .aclk    (aclk),
        .wr_en   (start_fire),
        .wr_addr (note_reg),
        .wr_data (chosen_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign mapped_voice = rd_hit_reg ? rd_data : '0;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_ready_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            sample_ready_reg <= cfg_data;
        end
    end

    // Note map valid bits and read hit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_valid_reg <= '0;
            rd_hit_reg   <= 1'b0;
        end else begin
            if (start_fire) begin
                nv_valid_reg[note_reg] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= nv_valid_reg[rd_addr];
            end
        end
    end

    // Sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            scan_cnt_reg    <= '0;
            inact_found_reg <= 1'b0;
            rel_cnt_reg     <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        note_reg        <= s_note;
                        vel_reg         <= s_velocity;
                        scan_cnt_reg    <= '0;
                        inact_found_reg <= 1'b0;
                        rel_cnt_reg     <= '0;
                        if (sample_ready_reg) begin
                            case (s_operation)
                                OP_NOTE_ON:  state_reg <= ST_ON_SCAN;
                                OP_NOTE_OFF: state_reg <= ST_OFF_WAIT;
                                OP_ALL_OFF:  state_reg <= ST_ALL_SCAN;
                                default:     state_reg <= ST_IDLE;
                            endcase
                        end
                    end
                end
                ST_ON_SCAN: begin
                    if (match_vec[scan_cnt_reg]) begin
                        // reuse the voice already playing this note
                        pos_reg    <= scan_cnt_reg;
                        chosen_reg <= scan_slot.id;
                        state_reg  <= ST_ON_CANCEL;
                    end else begin
                        if (!scan_slot.active && !inact_found_reg) begin
                            inact_found_reg <= 1'b1;
                            inact_pos_reg   <= scan_cnt_reg;
                            inact_id_reg    <= scan_slot.id;
                        end
                        if (scan_cnt_reg == LAST_SLOT) begin
                            if (inact_found_reg) begin
                                pos_reg    <= inact_pos_reg;
                                chosen_reg <= inact_id_reg;
                                state_reg  <= ST_ON_START;
                            end else if (!scan_slot.active) begin
                                pos_reg    <= scan_cnt_reg;
                                chosen_reg <= scan_slot.id;
                                state_reg  <= ST_ON_START;
                            end else begin
                                // steal the oldest voice
                                pos_reg    <= '0;
                                chosen_reg <= cells_q[0].id;
                                state_reg  <= ST_ON_CANCEL;
                            end
                        end else begin
                            scan_cnt_reg <= scan_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_ON_CANCEL: begin
                    if (out_free) begin
                        m_command_reg        <= CMD_CANCEL;
                        m_voice_reg          <= chosen_reg;
                        m_voice_note_reg     <= '0;
                        m_voice_velocity_reg <= '0;
                        m_last_reg           <= 1'b0;
                        state_reg            <= ST_ON_START;
                    end
                end
                ST_ON_START: begin
                    if (out_free) begin
                        m_command_reg        <= CMD_START;
                        m_voice_reg          <= chosen_reg;
                        m_voice_note_reg     <= note_reg;
                        m_voice_velocity_reg <= vel_reg;
                        m_last_reg           <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                ST_OFF_WAIT: begin
                    if (out_free) begin
                        m_command_reg        <= CMD_RELEASE;
                        m_voice_reg          <= mapped_voice;
                        m_voice_note_reg     <= '0;
                        m_voice_velocity_reg <= '0;
                        m_last_reg           <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                ST_ALL_SCAN: begin
                    if (act_vec[scan_cnt_reg]) begin
                        state_reg <= ST_ALL_WAIT;
                    end else if (scan_cnt_reg == LAST_SLOT) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                ST_ALL_WAIT: begin
                    if (out_free) begin
                        m_command_reg        <= CMD_RELEASE;
                        m_voice_reg          <= mapped_voice;
                        m_voice_note_reg     <= '0;
                        m_voice_velocity_reg <= '0;
                        m_last_reg           <= rel_last;
                        rel_cnt_reg          <= rel_cnt_reg + 1'b1;
                        if (rel_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            scan_cnt_reg <= scan_cnt_reg + 1'b1;
                            state_reg    <= ST_ALL_SCAN;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_command        = m_command_reg;
    assign m_voice          = m_voice_reg;
    assign m_voice_note     = m_voice_note_reg;
    assign m_voice_velocity = m_voice_velocity_reg;
    assign m_last           = m_last_reg;

    // Voice zero is always held by exactly one slot of the row
    a_row_perm: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(id0_vec))
        else $error("voice zero not held by exactly one slot");

    // A started voice lands active at the newest position
    a_start_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        start_fire |=> (cells_q[VOICES-1].id == m_voice_reg) && cells_q[VOICES-1].active)
        else $error("started voice not at newest position");

    // A start always ends its note on, a cancel never does
    a_start_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_command_reg == CMD_START) |-> m_last_reg)
        else $error("start without last");

    a_cancel_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_command_reg == CMD_CANCEL) |-> !m_last_reg)
        else $error("cancel marked last");

endmodule

`default_nettype wire

// ----- rtl/pva_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pva_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/pva_cell.sv -----
// One cell of the LRU row: holds one voice slot and shifts from its neighbor.
`default_nettype none

module pva_cell
    import pva_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [VOICE_W-1:0] slot_idx,
    input  wire cell_ctrl_t         ctrl,
    input  wire slot_t              nb_in,
    output slot_t                   q,
    output logic                    match
);

    slot_t slot_reg;

    // Take the neighbor's slot at and above the removed position; drop active on finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.id     <= slot_idx;
            slot_reg.active <= 1'b0;
            slot_reg.key    <= '0;
        end else if (ctrl.shift && (slot_idx >= ctrl.pos)) begin
            slot_reg <= nb_in;
        end else if (ctrl.clear && (slot_reg.id == ctrl.fin)) begin
            slot_reg.active <= 1'b0;
        end
    end

    // Flag an active voice already playing the searched note
    assign match = slot_reg.active && (slot_reg.key == ctrl.note);
    assign q     = slot_reg;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the polyphonic voice allocator: directed and random MIDI events.
`timescale 1ns / 100ps

module tb;
    import pva_pkg::*;

    localparam int SETTLE_CYCLES = 2 * VOICES + 8;

    // One voice command as the block should emit it
    typedef struct {
        cmd_t               cmd;
        logic [VOICE_W-1:0] voice;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   vel;
        logic               last;
    } voice_cmd_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation = '0;
    logic [NOTE_W-1:0]  s_note = '0;
    logic [VEL_W-1:0]   s_velocity = '0;
    logic [VOICE_W-1:0] s_finished_voice = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_command;
    logic [VOICE_W-1:0] m_voice;
    logic [NOTE_W-1:0]  m_voice_note;
    logic [VEL_W-1:0]   m_voice_velocity;
    logic               m_last;

    // Allocator state mirrored by the testbench
    logic [VOICE_W-1:0] age_order [VOICES];
    bit                 voice_busy [VOICES];
    logic [NOTE_W-1:0]  voice_note_of [VOICES];
    logic [VOICE_W-1:0] note_owner [NOTES];
    bit                 sample_loaded;

    voice_cmd_t pending_cmds[$];
    int         mismatches = 0;
    bit         gaps_on = 1'b1;

    polyphonic_voice_allocator u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_note           (s_note),
        .s_velocity       (s_velocity),
        .s_finished_voice (s_finished_voice),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command        (m_command),
        .m_voice          (m_voice),
        .m_voice_note     (m_voice_note),
        .m_voice_velocity (m_voice_velocity),
        .m_last           (m_last)
    );

    always #10 aclk = ~aclk;

    // Stall the result channel about a third of the time while gaps are on
    always @(negedge aclk) begin
        m_ready <= gaps_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
    end

    // Queue one expected command
    function automatic void expect_cmd(cmd_t cmd, logic [VOICE_W-1:0] v,
                                       logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vel);
        voice_cmd_t c;
        c.cmd   = cmd;
        c.voice = v;
        c.note  = nt;
        c.vel   = vel;
        c.last  = 1'b0;
        pending_cmds.push_back(c);
    endfunction

    function automatic void clear_allocator();
        for (int i = 0; i < VOICES; i++) begin
            age_order[i]     = VOICE_W'(i);
            voice_busy[i]    = 1'b0;
            voice_note_of[i] = '0;
        end
        for (int n = 0; n < NOTES; n++) note_owner[n] = '0;
        sample_loaded = 1'b0;
    endfunction

    // Pick a voice for a note: reuse, first idle in age order, else steal the oldest
    function automatic void allocate_note(logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vel);
        int                 pos;
        logic [VOICE_W-1:0] v;
        pos = -1;
        for (int i = 0; i < VOICES && pos < 0; i++) begin
            v = age_order[i];
            if (voice_busy[v] && voice_note_of[v] == nt) begin
                pos = i;
                expect_cmd(CMD_CANCEL, v, '0, '0);
            end
        end
        for (int i = 0; i < VOICES && pos < 0; i++) begin
            if (!voice_busy[age_order[i]]) pos = i;
        end
        if (pos < 0) begin
            pos = 0;
            expect_cmd(CMD_CANCEL, age_order[0], '0, '0);
        end
        v = age_order[pos];
        for (int i = pos; i + 1 < VOICES; i++) age_order[i] = age_order[i + 1];
        age_order[VOICES - 1] = v;
        note_owner[nt]   = v;
        voice_note_of[v] = nt;
        voice_busy[v]    = 1'b1;
        expect_cmd(CMD_START, v, nt, vel);
    endfunction

    // Update the mirrored state for one accepted event and queue its commands
    function automatic void apply_midi_event(op_t op, logic [NOTE_W-1:0] nt,
                                             logic [VEL_W-1:0] vel,
                                             logic [VOICE_W-1:0] fin);
        int first;
        int emitted;
        first = pending_cmds.size();
        if (op == OP_VOICE_DONE) begin
            if (int'(fin) < VOICES) voice_busy[fin] = 1'b0;
            return;
        end
        if (!sample_loaded) return;
        case (op)
            OP_NOTE_ON: begin
                allocate_note(nt, vel);
            end
            OP_NOTE_OFF: begin
                expect_cmd(CMD_RELEASE, note_owner[nt], '0, '0);
            end
            default: begin
                emitted = 0;
                for (int v = 0; v < VOICES && emitted < MAX_RESULTS; v++) begin
                    if (voice_busy[v]) begin
                        expect_cmd(CMD_RELEASE, note_owner[voice_note_of[v]], '0, '0);
                        emitted++;
                    end
                end
            end
        endcase
        if (pending_cmds.size() > first) pending_cmds[pending_cmds.size() - 1].last = 1'b1;
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Check each accepted command against the oldest expectation
    always @(posedge aclk) begin
        voice_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                log_mismatch($sformatf("unexpected word cmd=%0d voice=%0d note=%0d vel=%0d last=%0d",
                             m_command, m_voice, m_voice_note, m_voice_velocity, m_last));
            end else begin
                want = pending_cmds.pop_front();
                if (m_command !== want.cmd || m_voice !== want.voice ||
                    m_voice_note !== want.note || m_voice_velocity !== want.vel ||
                    m_last !== want.last) begin
                    log_mismatch($sformatf({"expected cmd=%0d voice=%0d note=%0d vel=%0d ",
                                 "last=%0d, got cmd=%0d voice=%0d note=%0d vel=%0d last=%0d"},
                                 want.cmd, want.voice, want.note, want.vel, want.last,
                                 m_command, m_voice, m_voice_note, m_voice_velocity, m_last));
                end
            end
        end
    end

    // Present one event, hold it until taken, then account for it
    task automatic send_event(op_t op, logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vel,
                              logic [VOICE_W-1:0] fin);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 33) begin
            s_valid          = 1'b0;
            s_operation      = 2'($urandom);
            s_note           = NOTE_W'($urandom);
            s_velocity       = VEL_W'($urandom);
            s_finished_voice = VOICE_W'($urandom);
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_operation      = op;
        s_note           = nt;
        s_velocity       = vel;
        s_finished_voice = fin;
        do @(posedge aclk); while (!s_ready);
        apply_midi_event(op, nt, vel, fin);
    endtask

    // Drop valid, wait for every expected word, then let the block settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sample_ready(bit value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sample_loaded = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Note events before a sample is loaded must be dropped
    task automatic test_not_ready();
        send_event(OP_NOTE_ON, 7'd60, 7'd100, 4'd0);
        send_event(OP_NOTE_OFF, 7'd60, 7'd0, 4'd0);
        send_event(OP_ALL_OFF, 7'd0, 7'd0, 4'd0);
        send_event(OP_VOICE_DONE, 7'd0, 7'd0, 4'd3);
        wait_idle();
    endtask

    // Field extremes, retrigger, release of an unmapped note, empty all-off
    task automatic test_note_basics();
        send_event(OP_ALL_OFF, 7'd0, 7'd0, 4'd0);
        send_event(OP_NOTE_OFF, 7'd0, 7'd0, 4'd0);
        send_event(OP_NOTE_ON, 7'd0, 7'd0, 4'd0);
        send_event(OP_NOTE_ON, 7'd127, 7'd127, 4'd15);
        send_event(OP_NOTE_ON, 7'd127, 7'd1, 4'd0);
        send_event(OP_NOTE_OFF, 7'd127, 7'd127, 4'd15);
        send_event(OP_VOICE_DONE, 7'd127, 7'd127, 4'd0);
        send_event(OP_ALL_OFF, 7'd127, 7'd127, 4'd15);
        wait_idle();
    endtask

    // Fill the pool, steal the oldest voice, then release all sixteen at once
    task automatic test_voice_steal();
        for (int i = 0; i < VOICES; i++) begin
            send_event(OP_NOTE_ON, NOTE_W'(20 + i), VEL_W'(64 + i), 4'd0);
        end
        send_event(OP_NOTE_ON, 7'd90, 7'd90, 4'd0);
        send_event(OP_ALL_OFF, 7'd0, 7'd0, 4'd0);
        wait_idle();
    endtask

    // Mostly note traffic on a small key set so reuse and stealing happen often
    task automatic test_random_traffic(int count);
        op_t                op;
        logic [NOTE_W-1:0]  nt;
        int                 pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      op = OP_NOTE_ON;
            else if (pick < 68) op = OP_NOTE_OFF;
            else if (pick < 74) op = OP_ALL_OFF;
            else                op = OP_VOICE_DONE;
            if ($urandom_range(0, 3) == 0) nt = NOTE_W'($urandom);
            else                           nt = NOTE_W'(40 + $urandom_range(0, 23));
            send_event(op, nt, VEL_W'($urandom), VOICE_W'($urandom));
        end
        wait_idle();
    endtask

    initial begin
        clear_allocator();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_not_ready();
        write_sample_ready(1'b1);
        test_note_basics();
        test_voice_steal();
        test_random_traffic(200);

        // long stretch with both sides always ready
        gaps_on = 1'b0;
        test_random_traffic(120);
        gaps_on = 1'b1;

        write_sample_ready(1'b0);
        test_random_traffic(30);
        write_sample_ready(1'b1);
        test_random_traffic(70);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- polyphonic_voice_allocator.f -----
rtl/pva_pkg.sv
rtl/pva_ram.sv
rtl/pva_cell.sv
rtl/polyphonic_voice_allocator.sv
verif/tb.sv
